>>> rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared widths, codes and types for the bounded subinterval counter.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  // Width of a position or a length
  localparam int unsigned POS_WIDTH  = 31;
  // A range size reaches 2^POS_WIDTH, so one extra bit
  localparam int unsigned N_W        = POS_WIDTH + 1;
  // Sum of the first and last term of the arithmetic series
  localparam int unsigned S_W        = POS_WIDTH + 2;
  // Any count fits below 2^(2*POS_WIDTH)
  localparam int unsigned CNT_W      = 2 * POS_WIDTH;
  localparam int unsigned TOTAL_W    = 62;
  localparam int unsigned SAT_W      = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam int unsigned IN_DATA_W  = ((4 * POS_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((TOTAL_W + 7) / 8) * 8;
  localparam int unsigned CASE_W     = 2;

  // Inclusion-exclusion terms
  localparam int unsigned NUM_TERMS  = 4;
  localparam int unsigned TERM_T     = 0;
  localparam int unsigned TERM_L     = 1;
  localparam int unsigned TERM_R     = 2;
  localparam int unsigned TERM_C     = 3;

  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic [CASE_W-1:0] {
    CASE_DISJOINT = 2'd0,
    CASE_EQUAL    = 2'd1,
    CASE_OVERLAP  = 2'd2
  } bsc_case_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LEN = 1'b0,
    REG_MAX_LEN = 1'b1
  } bsc_reg_e;

  typedef logic [POS_WIDTH-1:0] bsc_pos_t;
  typedef logic [N_W-1:0]       bsc_len_t;
  typedef logic [CNT_W-1:0]     bsc_cnt_t;

  // Load enables for the three stages inside a span unit
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } bsc_adv_t;

endpackage

`default_nettype wire

>>> rtl/bounded_subinterval_counter_unit.sv
// An accepted input transaction reaches the master side through the five
// register stages (classify, clamp, series operands, multiply, combine).
// Throughput: one transaction per cycle while the master side accepts.
// Each stage stalls only when it is full and the stage after it is blocked.
// Reset clears all valid bits and sets min_len to 1 and max_len to all ones.
// ----------------------------------------------------------------------------
// bounded_subinterval_counter_unit
// Counts intervals with start and end in given ranges and bounded length.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_subinterval_counter_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [bsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire bsc_pkg::bsc_pos_t                  cfg_wdata_i,
  // query stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata: start_lo, start_hi, end_lo, end_hi
  input  wire logic [bsc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tdata: interval_total
  output logic [bsc_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  // tuser: range_case
  output logic [bsc_pkg::CASE_W-1:0]              m_axis_tuser
);
  import bsc_pkg::*;

  localparam int unsigned NUM_STAGES = 5;

  bsc_pos_t                 min_len_d, min_len_q, max_len_d, max_len_q;
  logic [NUM_STAGES-1:0]    valid_d, valid_q, ready;
  bsc_adv_t                 adv;

  bsc_len_t [NUM_TERMS-1:0] n1;
  logic [NUM_TERMS-1:0]     nz1;
  bsc_case_e                case1, case2_q, case3_q, case4_q;
  logic                     live1, live2_q, live3_q, live4_q;
  bsc_cnt_t [NUM_TERMS-1:0] cnt4;

  // Configuration; min_len is kept as its effective value (at least one)
  always_comb begin
    min_len_d = min_len_q;
    max_len_d = max_len_q;
    if (cfg_we_i) begin
      case (bsc_reg_e'(cfg_idx_i))
        REG_MIN_LEN: min_len_d = (cfg_wdata_i == '0) ? POS_WIDTH'(1) : cfg_wdata_i;
        REG_MAX_LEN: max_len_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= POS_WIDTH'(1);
      max_len_q <= '1;
    end else begin
      min_len_q <= min_len_d;
      max_len_q <= max_len_d;
    end
  end

  // A stage loads when it is empty or its content moves on
  always_comb begin
    ready[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || m_axis_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ready[i] = !valid_q[i] || ready[i+1];
    end
    valid_d[0] = ready[0] ? s_axis_tvalid : valid_q[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      valid_d[i] = ready[i] ? valid_q[i-1] : valid_q[i];
    end
    adv.s2 = ready[1];
    adv.s3 = ready[2];
    adv.s4 = ready[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = ready[0];
  assign m_axis_tvalid = valid_q[NUM_STAGES-1];

  bsc_prep u_prep (
    .clk_i      (clk_i),
    .en_i       (ready[0]),
    .start_lo_i (s_axis_tdata[POS_WIDTH-1:0]),
    .start_hi_i (s_axis_tdata[2*POS_WIDTH-1:POS_WIDTH]),
    .end_lo_i   (s_axis_tdata[3*POS_WIDTH-1:2*POS_WIDTH]),
    .end_hi_i   (s_axis_tdata[4*POS_WIDTH-1:3*POS_WIDTH]),
    .n_o        (n1),
    .nz_o       (nz1),
    .case_o     (case1),
    .live_o     (live1)
  );

  // Carry the classification alongside the span units
  always_ff @(posedge clk_i) begin
    if (adv.s2) begin
      case2_q <= case1;
      live2_q <= live1;
    end
    if (adv.s3) begin
      case3_q <= case2_q;
      live3_q <= live2_q;
    end
    if (adv.s4) begin
      case4_q <= case3_q;
      live4_q <= live3_q;
    end
  end

  for (genvar g = 0; g < NUM_TERMS; g++) begin : g_span
    bsc_span u_span (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .dmin_i (min_len_q),
      .dmax_i (max_len_q),
      .n_i    (n1[g]),
      .nz_i   (nz1[g]),
      .cnt_o  (cnt4[g])
    );
  end

  bsc_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (ready[NUM_STAGES-1]),
    .live_i  (live4_q),
    .case_i  (case4_q),
    .cnt_i   (cnt4),
    .tdata_o (m_axis_tdata),
    .tuser_o (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> rtl/bsc_prep.sv
// ----------------------------------------------------------------------------
// bsc_prep
// Stage 1: classify the two ranges and form the size of each term's span.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_prep (
  input  wire logic                                      clk_i,
  input  wire logic                                      en_i,
  input  wire bsc_pkg::bsc_pos_t                         start_lo_i,
  input  wire bsc_pkg::bsc_pos_t                         start_hi_i,
  input  wire bsc_pkg::bsc_pos_t                         end_lo_i,
  input  wire bsc_pkg::bsc_pos_t                         end_hi_i,
  output bsc_pkg::bsc_len_t [bsc_pkg::NUM_TERMS-1:0]     n_o,
  output logic [bsc_pkg::NUM_TERMS-1:0]                  nz_o,
  output bsc_pkg::bsc_case_e                             case_o,
  output logic                                           live_o
);
  import bsc_pkg::*;

  bsc_len_t [NUM_TERMS-1:0] lo, hi1;
  bsc_len_t [NUM_TERMS-1:0] n_d, n_q;
  logic [NUM_TERMS-1:0]     nz_d, nz_q;
  bsc_len_t                 slo, elo, shi_p1, ehi_p1;
  logic                     disjoint, equal, empty;
  bsc_case_e                case_d, case_q;
  logic                     live_d, live_q;

  // Spans are [lo, hi1) with hi1 one past the last position
  always_comb begin
    slo    = {1'b0, start_lo_i};
    elo    = {1'b0, end_lo_i};
    shi_p1 = {1'b0, start_hi_i} + N_W'(1);
    ehi_p1 = {1'b0, end_hi_i} + N_W'(1);

    lo[TERM_T] = slo;    hi1[TERM_T] = ehi_p1;
    lo[TERM_L] = slo;    hi1[TERM_L] = elo;
    lo[TERM_R] = shi_p1; hi1[TERM_R] = ehi_p1;
    lo[TERM_C] = shi_p1; hi1[TERM_C] = elo;

    for (int i = 0; i < NUM_TERMS; i++) begin
      n_d[i]  = hi1[i] - lo[i];
      nz_d[i] = hi1[i] > lo[i];
    end

    disjoint = (start_hi_i < end_lo_i) || (end_hi_i < start_lo_i);
    equal    = (start_lo_i == end_lo_i) && (start_hi_i == end_hi_i);
    empty    = (start_lo_i > start_hi_i) || (end_lo_i > end_hi_i);

    if (disjoint) begin
      case_d = CASE_DISJOINT;
    end else if (equal) begin
      case_d = CASE_EQUAL;
    end else begin
      case_d = CASE_OVERLAP;
    end
    live_d = !empty && (disjoint || equal);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      nz_q   <= nz_d;
      case_q <= case_d;
      live_q <= live_d;
    end
  end

  assign n_o    = n_q;
  assign nz_o   = nz_q;
  assign case_o = case_q;
  assign live_o = live_q;

endmodule

`default_nettype wire

>>> rtl/bsc_span.sv
// ----------------------------------------------------------------------------
// bsc_span
// Stages 2 to 4: count the intervals of bounded length inside one span.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_span (
  input  wire logic               clk_i,
  input  wire bsc_pkg::bsc_adv_t  adv_i,
  input  wire bsc_pkg::bsc_pos_t  dmin_i,
  input  wire bsc_pkg::bsc_pos_t  dmax_i,
  input  wire bsc_pkg::bsc_len_t  n_i,
  input  wire logic               nz_i,
  output bsc_pkg::bsc_cnt_t       cnt_o
);
  import bsc_pkg::*;

  bsc_len_t             dmin_n, dmax_n;

  // stage 2
  bsc_len_t             n_q, m_d, m_q;
  logic                 zero2_d, zero2_q;

  // stage 3
  bsc_len_t             k, a, b;
  logic [S_W-1:0]       s;
  bsc_len_t             opa_d, opa_q;
  logic [S_W-1:0]       opb_d, opb_q;
  logic                 zero3_q;

  // stage 4
  logic [N_W+S_W-1:0]   prod;
  bsc_cnt_t             cnt_d, cnt_q;

  assign dmin_n = {1'b0, dmin_i};
  assign dmax_n = {1'b0, dmax_i};

  always_comb begin
    zero2_d = !nz_i || (n_i < dmin_n) || (dmax_i < dmin_i);
    m_d     = (n_i < dmax_n) ? n_i : dmax_n;
  end

  // Series of (n+1-d) for d in [dmin, m]: k terms, first a, last b
  always_comb begin
    k = m_q - dmin_n + N_W'(1);
    a = n_q + N_W'(1) - dmin_n;
    b = n_q + N_W'(1) - m_q;
    s = S_W'(a) + S_W'(b);
    // halve whichever factor is even
    if (k[0]) begin
      opa_d = k;
      opb_d = {1'b0, s[S_W-1:1]};
    end else begin
      opa_d = {1'b0, k[N_W-1:1]};
      opb_d = s;
    end
  end

  always_comb begin
    prod  = (N_W+S_W)'(opa_q) * (N_W+S_W)'(opb_q);
    cnt_d = zero3_q ? '0 : prod[CNT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      n_q     <= n_i;
      m_q     <= m_d;
      zero2_q <= zero2_d;
    end
    if (adv_i.s3) begin
      opa_q   <= opa_d;
      opb_q   <= opb_d;
      zero3_q <= zero2_q;
    end
    if (adv_i.s4) begin
      cnt_q   <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

`default_nettype wire

>>> rtl/bsc_merge.sv
// ----------------------------------------------------------------------------
// bsc_merge
// Stage 5: combine the term counts, saturate, and hold the output item.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_merge (
  input  wire logic                                     clk_i,
  input  wire logic                                     en_i,
  input  wire logic                                     live_i,
  input  wire bsc_pkg::bsc_case_e                       case_i,
  input  wire bsc_pkg::bsc_cnt_t [bsc_pkg::NUM_TERMS-1:0] cnt_i,
  output logic [bsc_pkg::OUT_DATA_W-1:0]                tdata_o,
  output logic [bsc_pkg::CASE_W-1:0]                    tuser_o
);
  import bsc_pkg::*;

  bsc_cnt_t                diff, total;
  logic [SAT_W-1:0]        total_ext;
  logic [TOTAL_W-1:0]      total_sat;
  logic [OUT_DATA_W-1:0]   tdata_d, tdata_q;
  logic [CASE_W-1:0]       tuser_q;

  // Wrapping arithmetic is exact since the true count is never negative
  always_comb begin
    diff = (cnt_i[TERM_T] - cnt_i[TERM_L]) - (cnt_i[TERM_R] - cnt_i[TERM_C]);
    if (!live_i) begin
      total = '0;
    end else if (case_i == CASE_DISJOINT) begin
      total = diff;
    end else begin
      total = cnt_i[TERM_T];
    end
    total_ext = SAT_W'(total);
    total_sat = (total_ext > SAT_W'(TOTAL_MAX)) ? TOTAL_MAX : total_ext[TOTAL_W-1:0];
    tdata_d   = OUT_DATA_W'(total_sat);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tdata_q <= tdata_d;
      tuser_q <= case_i;
    end
  end

  assign tdata_o = tdata_q;
  assign tuser_o = tuser_q;

endmodule

`default_nettype wire

>>> rtl/bsc_check.sv
// ----------------------------------------------------------------------------
// bsc_check
// Port-level checks on the bounded subinterval counter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_check (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  input  wire logic                               s_axis_tready,
  input  wire logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic [bsc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  wire logic [bsc_pkg::CASE_W-1:0]         m_axis_tuser
);
  import bsc_pkg::*;

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Overlapping unequal ranges count nothing
  a_overlap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == CASE_OVERLAP) |-> (m_axis_tdata == '0))
    else $error("nonzero total for overlapping ranges");

  // Input backpressure only when the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // With the output draining, an accepted transaction reaches the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready) |=> m_axis_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind bounded_subinterval_counter_unit bsc_check u_bsc_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
